// File: src/kfcp_pkg.sv
// Shared types, constants and the sequencer micro-program for the two-state
// Kalman filter. No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package kfcp_pkg;

	localparam int FRAC = 16;
	localparam int HALF = 32768;

	typedef logic signed [31:0] val_t;
	typedef logic signed [65:0] acc_t;
	typedef logic signed [63:0] prod_t;
	typedef logic signed [47:0] det_t;

	// Reset value of the diagonal covariance and measurement noise (100.0)
	localparam val_t P_INIT = 32'sd6553600;
	localparam int N_STATE = 5;

	// Configuration register indexes
	localparam logic [2:0] R_T11 = 3'd0;
	localparam logic [2:0] R_T12 = 3'd1;
	localparam logic [2:0] R_T21 = 3'd2;
	localparam logic [2:0] R_T22 = 3'd3;
	localparam logic [2:0] R_QX = 3'd4;
	localparam logic [2:0] R_QY = 3'd5;
	localparam logic [2:0] R_RX = 3'd6;
	localparam logic [2:0] R_RY = 3'd7;

	// Operation kinds
	localparam logic [1:0] K_ADD = 2'd0;
	localparam logic [1:0] K_MUL = 2'd1;
	localparam logic [1:0] K_RAW = 2'd2;
	localparam logic [1:0] K_DIV = 2'd3;

	// Write modes
	localparam logic [1:0] W_SAT = 2'd0;
	localparam logic [1:0] W_CLAMP = 2'd1;
	localparam logic [1:0] W_DET = 2'd2;

	// Scratch memory addresses; the first five hold the filter state
	localparam logic [5:0] A_P11 = 6'd0;
	localparam logic [5:0] A_P12 = 6'd1;
	localparam logic [5:0] A_P22 = 6'd2;
	localparam logic [5:0] A_X1 = 6'd3;
	localparam logic [5:0] A_X2 = 6'd4;
	localparam logic [5:0] A_S11 = 6'd5;
	localparam logic [5:0] A_S22 = 6'd6;
	localparam logic [5:0] A_I11 = 6'd7;
	localparam logic [5:0] A_I12 = 6'd8;
	localparam logic [5:0] A_I22 = 6'd9;
	localparam logic [5:0] A_K11 = 6'd10;
	localparam logic [5:0] A_K12 = 6'd11;
	localparam logic [5:0] A_K21 = 6'd12;
	localparam logic [5:0] A_K22 = 6'd13;
	localparam logic [5:0] A_E1 = 6'd14;
	localparam logic [5:0] A_E2 = 6'd15;
	localparam logic [5:0] A_XU1 = 6'd16;
	localparam logic [5:0] A_XU2 = 6'd17;
	localparam logic [5:0] A_G11 = 6'd18;
	localparam logic [5:0] A_G12 = 6'd19;
	localparam logic [5:0] A_G22 = 6'd20;
	localparam logic [5:0] A_M11 = 6'd21;
	localparam logic [5:0] A_M12 = 6'd22;
	localparam logic [5:0] A_M21 = 6'd23;
	localparam logic [5:0] A_M22 = 6'd24;
	localparam logic [5:0] A_C11 = 6'd25;
	localparam logic [5:0] A_N12 = 6'd26;
	localparam logic [5:0] A_C22 = 6'd27;
	localparam logic [5:0] A_NX1 = 6'd28;
	localparam logic [5:0] A_NX2 = 6'd29;

	// Operands outside the scratch memory
	localparam logic [5:0] E_T11 = 6'd32;
	localparam logic [5:0] E_T12 = 6'd33;
	localparam logic [5:0] E_T21 = 6'd34;
	localparam logic [5:0] E_T22 = 6'd35;
	localparam logic [5:0] E_QX = 6'd36;
	localparam logic [5:0] E_QY = 6'd37;
	localparam logic [5:0] E_RX = 6'd38;
	localparam logic [5:0] E_RY = 6'd39;
	localparam logic [5:0] E_Y1 = 6'd40;
	localparam logic [5:0] E_Y2 = 6'd41;
	localparam logic [5:0] E_U1 = 6'd42;
	localparam logic [5:0] E_U2 = 6'd43;

	// Program points where the sequencer branches
	localparam logic [6:0] PC_DET = 7'd5;
	localparam logic [6:0] PC_CEND = 7'd35;
	localparam logic [6:0] PC_COPY = 7'd36;
	localparam logic [6:0] PC_PRED = 7'd41;
	localparam logic [6:0] PC_COMMIT = 7'd63;
	localparam logic [6:0] PC_LAST = 7'd67;

	typedef struct packed {
		logic [1:0] kind;
		logic       neg;
		logic       last;
		logic [1:0] wmode;
		logic [5:0] srca;
		logic [5:0] srcb;
		logic [4:0] dest;
	} instr_t;

	typedef struct packed {
		val_t        t11;
		val_t        t12;
		val_t        t21;
		val_t        t22;
		logic [30:0] qx;
		logic [30:0] qy;
		logic [30:0] rx;
		logic [30:0] ry;
	} cfg_t;

	typedef struct packed {
		logic       en;
		logic [4:0] addr;
		val_t       data;
	} wr_t;

	function automatic val_t sat(input acc_t v);
		if (v > 66'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -66'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// Round half up, floor shift, saturate
	function automatic val_t rnd_sat(input prod_t p);
		acc_t t;
		t = (acc_t'(p) + acc_t'(HALF)) >>> FRAC;
		return sat(t);
	endfunction

	function automatic instr_t mk(input logic [1:0] k, input logic n, input logic [5:0] a,
		input logic [5:0] b, input logic l, input logic [1:0] w, input logic [5:0] d);
		instr_t r;
		r.kind = k;
		r.neg = n;
		r.srca = a;
		r.srcb = b;
		r.last = l;
		r.wmode = w;
		r.dest = d[4:0];
		return r;
	endfunction

	function automatic instr_t term(input logic [1:0] k, input logic n, input logic [5:0] a,
		input logic [5:0] b);
		return mk(k, n, a, b, 1'b0, W_SAT, A_P11);
	endfunction

	function automatic instr_t fin(input logic [1:0] k, input logic n, input logic [5:0] a,
		input logic [5:0] b, input logic [1:0] w, input logic [5:0] d);
		return mk(k, n, a, b, 1'b1, w, d);
	endfunction

	// Micro-program: correct, then predict, then commit the new state
	function automatic instr_t prog(input logic [6:0] pc);
		instr_t r;
		case (pc)
			// innovation covariance and its determinant
			7'd0: r = term(K_ADD, 1'b0, A_P11, A_P11);
			7'd1: r = fin(K_ADD, 1'b0, E_RX, E_RX, W_SAT, A_S11);
			7'd2: r = term(K_ADD, 1'b0, A_P22, A_P22);
			7'd3: r = fin(K_ADD, 1'b0, E_RY, E_RY, W_SAT, A_S22);
			7'd4: r = term(K_RAW, 1'b0, A_S11, A_S22);
			7'd5: r = fin(K_RAW, 1'b1, A_P12, A_P12, W_DET, A_P11);
			// inverse
			7'd6: r = fin(K_DIV, 1'b0, A_S22, A_S22, W_SAT, A_I11);
			7'd7: r = fin(K_DIV, 1'b1, A_P12, A_P12, W_SAT, A_I12);
			7'd8: r = fin(K_DIV, 1'b0, A_S11, A_S11, W_SAT, A_I22);
			// gain
			7'd9: r = term(K_MUL, 1'b0, A_P11, A_I11);
			7'd10: r = fin(K_MUL, 1'b0, A_P12, A_I12, W_SAT, A_K11);
			7'd11: r = term(K_MUL, 1'b0, A_P11, A_I12);
			7'd12: r = fin(K_MUL, 1'b0, A_P12, A_I22, W_SAT, A_K12);
			7'd13: r = term(K_MUL, 1'b0, A_P12, A_I11);
			7'd14: r = fin(K_MUL, 1'b0, A_P22, A_I12, W_SAT, A_K21);
			7'd15: r = term(K_MUL, 1'b0, A_P12, A_I12);
			7'd16: r = fin(K_MUL, 1'b0, A_P22, A_I22, W_SAT, A_K22);
			// residual
			7'd17: r = term(K_ADD, 1'b0, E_Y1, E_Y1);
			7'd18: r = fin(K_ADD, 1'b1, A_X1, A_X1, W_SAT, A_E1);
			7'd19: r = term(K_ADD, 1'b0, E_Y2, E_Y2);
			7'd20: r = fin(K_ADD, 1'b1, A_X2, A_X2, W_SAT, A_E2);
			// state update
			7'd21: r = term(K_ADD, 1'b0, A_X1, A_X1);
			7'd22: r = term(K_MUL, 1'b0, A_K11, A_E1);
			7'd23: r = fin(K_MUL, 1'b0, A_K12, A_E2, W_SAT, A_XU1);
			7'd24: r = term(K_ADD, 1'b0, A_X2, A_X2);
			7'd25: r = term(K_MUL, 1'b0, A_K21, A_E1);
			7'd26: r = fin(K_MUL, 1'b0, A_K22, A_E2, W_SAT, A_XU2);
			// covariance update
			7'd27: r = term(K_ADD, 1'b0, A_P11, A_P11);
			7'd28: r = term(K_MUL, 1'b1, A_K11, A_P11);
			7'd29: r = fin(K_MUL, 1'b1, A_K12, A_P12, W_SAT, A_G11);
			7'd30: r = term(K_ADD, 1'b0, A_P12, A_P12);
			7'd31: r = term(K_MUL, 1'b1, A_K11, A_P12);
			7'd32: r = fin(K_MUL, 1'b1, A_K12, A_P22, W_SAT, A_G12);
			7'd33: r = term(K_ADD, 1'b0, A_P22, A_P22);
			7'd34: r = term(K_MUL, 1'b1, A_K21, A_P12);
			7'd35: r = fin(K_MUL, 1'b1, A_K22, A_P22, W_SAT, A_G22);
			// correction skipped: carry the prior through
			7'd36: r = fin(K_ADD, 1'b0, A_X1, A_X1, W_SAT, A_XU1);
			7'd37: r = fin(K_ADD, 1'b0, A_X2, A_X2, W_SAT, A_XU2);
			7'd38: r = fin(K_ADD, 1'b0, A_P11, A_P11, W_SAT, A_G11);
			7'd39: r = fin(K_ADD, 1'b0, A_P12, A_P12, W_SAT, A_G12);
			7'd40: r = fin(K_ADD, 1'b0, A_P22, A_P22, W_SAT, A_G22);
			// A * P
			7'd41: r = term(K_MUL, 1'b0, E_T11, A_G11);
			7'd42: r = fin(K_MUL, 1'b0, E_T12, A_G12, W_SAT, A_M11);
			7'd43: r = term(K_MUL, 1'b0, E_T11, A_G12);
			7'd44: r = fin(K_MUL, 1'b0, E_T12, A_G22, W_SAT, A_M12);
			7'd45: r = term(K_MUL, 1'b0, E_T21, A_G11);
			7'd46: r = fin(K_MUL, 1'b0, E_T22, A_G12, W_SAT, A_M21);
			7'd47: r = term(K_MUL, 1'b0, E_T21, A_G12);
			7'd48: r = fin(K_MUL, 1'b0, E_T22, A_G22, W_SAT, A_M22);
			// (A P) A^T + Q
			7'd49: r = term(K_MUL, 1'b0, A_M11, E_T11);
			7'd50: r = term(K_MUL, 1'b0, A_M12, E_T12);
			7'd51: r = fin(K_ADD, 1'b0, E_QX, E_QX, W_CLAMP, A_C11);
			7'd52: r = term(K_MUL, 1'b0, A_M11, E_T21);
			7'd53: r = fin(K_MUL, 1'b0, A_M12, E_T22, W_SAT, A_N12);
			7'd54: r = term(K_MUL, 1'b0, A_M21, E_T21);
			7'd55: r = term(K_MUL, 1'b0, A_M22, E_T22);
			7'd56: r = fin(K_ADD, 1'b0, E_QY, E_QY, W_CLAMP, A_C22);
			// A x + u
			7'd57: r = term(K_MUL, 1'b0, E_T11, A_XU1);
			7'd58: r = term(K_MUL, 1'b0, E_T12, A_XU2);
			7'd59: r = fin(K_ADD, 1'b0, E_U1, E_U1, W_SAT, A_NX1);
			7'd60: r = term(K_MUL, 1'b0, E_T21, A_XU1);
			7'd61: r = term(K_MUL, 1'b0, E_T22, A_XU2);
			7'd62: r = fin(K_ADD, 1'b0, E_U2, E_U2, W_SAT, A_NX2);
			// commit
			7'd63: r = fin(K_ADD, 1'b0, A_NX1, A_NX1, W_SAT, A_X1);
			7'd64: r = fin(K_ADD, 1'b0, A_NX2, A_NX2, W_SAT, A_X2);
			7'd65: r = fin(K_ADD, 1'b0, A_C11, A_C11, W_SAT, A_P11);
			7'd66: r = fin(K_ADD, 1'b0, A_N12, A_N12, W_SAT, A_P12);
			7'd67: r = fin(K_ADD, 1'b0, A_C22, A_C22, W_SAT, A_P22);
			default: r = term(K_ADD, 1'b0, A_P11, A_P11);
		endcase
		return r;
	endfunction

endpackage

// File: src/kfcp_mul.sv
// Bit-serial signed 32x32 multiplier, one multiplier bit per cycle.
// Depends on kfcp_pkg.
`timescale 1ns / 1ps

module kfcp_mul (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  kfcp_pkg::val_t       a,
	input  kfcp_pkg::val_t       b,
	output logic                 done,
	output kfcp_pkg::prod_t      prod
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] mcand_q;
	logic [32:0] hi_q;
	logic [31:0] lo_q;
	logic        neg_q;
	logic [31:0] ma;
	logic [31:0] mb;
	logic [32:0] sum;
	logic [63:0] mag;

	// operand magnitudes
	assign ma = a[31] ? (~32'(a) + 32'd1) : 32'(a);
	assign mb = b[31] ? (~32'(b) + 32'd1) : 32'(b);
	assign sum = hi_q + {1'b0, (lo_q[0] ? mcand_q : 32'd0)};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// shift-add datapath
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= ma;
			lo_q <= mb;
			hi_q <= '0;
			neg_q <= a[31] ^ b[31];
		end else if (busy_q) begin
			hi_q <= {1'b0, sum[32:1]};
			lo_q <= {sum[0], lo_q[31:1]};
		end
	end

	assign mag = {hi_q[31:0], lo_q};
	assign prod = neg_q ? (64'sd0 - $signed(mag)) : $signed(mag);
	assign done = done_q;

endmodule

// File: src/kfcp_div.sv
// Restoring divider, one quotient bit per cycle: (num << 16) / den, truncated
// toward zero and saturated. Depends on kfcp_pkg.
`timescale 1ns / 1ps

module kfcp_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  kfcp_pkg::val_t       num,
	input  logic                 neg,
	input  kfcp_pkg::det_t       den,
	output logic                 done,
	output kfcp_pkg::val_t       quo
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [47:0] rem_q;
	logic [47:0] q_q;
	logic [47:0] dv_q;
	logic        sgn_q;
	logic [31:0] mn;
	logic [49:0] trial;

	assign mn = num[31] ? (~32'(num) + 32'd1) : 32'(num);
	assign trial = {1'b0, rem_q, q_q[47]} - {2'b00, dv_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'd47) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// trial subtract and shift
	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= {mn, 16'd0};
			rem_q <= '0;
			dv_q <= 48'(den);
			sgn_q <= num[31] ^ neg;
		end else if (busy_q) begin
			if (!trial[49]) begin
				rem_q <= trial[47:0];
				q_q <= {q_q[46:0], 1'b1};
			end else begin
				rem_q <= {rem_q[46:0], q_q[47]};
				q_q <= {q_q[46:0], 1'b0};
			end
		end
	end

	assign quo = kfcp_pkg::sat(sgn_q ? (66'sd0 - kfcp_pkg::acc_t'(q_q))
		: kfcp_pkg::acc_t'(q_q));
	assign done = done_q;

endmodule

// File: src/kfcp_seq.sv
// Micro-programmed sequencer: scratch memory, accumulator and the shared
// serial multiplier and divider. Depends on kfcp_pkg, kfcp_mul, kfcp_div.
`timescale 1ns / 1ps

module kfcp_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  kfcp_pkg::cfg_t      cfg,
	input  kfcp_pkg::val_t      y1,
	input  kfcp_pkg::val_t      y2,
	input  kfcp_pkg::val_t      u1,
	input  kfcp_pkg::val_t      u2,
	input  logic                hold,
	output logic                busy,
	output kfcp_pkg::wr_t       wr,
	output logic                done
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_EXEC = 2'd2;
	localparam logic [1:0] ST_WAIT = 2'd3;

	logic [1:0]            st_q;
	logic [6:0]            pc_q;
	kfcp_pkg::acc_t        acc_q;
	kfcp_pkg::det_t        det_q;
	logic [4:0]            ok_q;
	kfcp_pkg::val_t        rda_q;
	kfcp_pkg::val_t        rdb_q;
	kfcp_pkg::val_t        mem [0:31];
	kfcp_pkg::instr_t      ins;
	kfcp_pkg::val_t        opa;
	kfcp_pkg::val_t        opb;
	kfcp_pkg::prod_t       prod;
	kfcp_pkg::val_t        quo;
	logic                  mul_done;
	logic                  div_done;
	logic                  mul_go;
	logic                  div_go;
	kfcp_pkg::acc_t        term;
	kfcp_pkg::acc_t        acc_nx;
	kfcp_pkg::acc_t        det_wide;
	kfcp_pkg::det_t        det_nx;
	logic                  step;
	kfcp_pkg::val_t        wval;

	assign ins = kfcp_pkg::prog(pc_q);

	// operand decode: configuration, latched inputs, or scratch memory
	function automatic kfcp_pkg::val_t opnd(input logic [5:0] c, input kfcp_pkg::val_t rd);
		kfcp_pkg::val_t v;
		unique case (c)
			kfcp_pkg::E_T11: v = cfg.t11;
			kfcp_pkg::E_T12: v = cfg.t12;
			kfcp_pkg::E_T21: v = cfg.t21;
			kfcp_pkg::E_T22: v = cfg.t22;
			kfcp_pkg::E_QX:  v = {1'b0, cfg.qx};
			kfcp_pkg::E_QY:  v = {1'b0, cfg.qy};
			kfcp_pkg::E_RX:  v = {1'b0, cfg.rx};
			kfcp_pkg::E_RY:  v = {1'b0, cfg.ry};
			kfcp_pkg::E_Y1:  v = y1;
			kfcp_pkg::E_Y2:  v = y2;
			kfcp_pkg::E_U1:  v = u1;
			kfcp_pkg::E_U2:  v = u2;
			default: begin
				if (c < 6'(kfcp_pkg::N_STATE) && !ok_q[c[2:0]]) begin
					v = (c == kfcp_pkg::A_P11 || c == kfcp_pkg::A_P22) ?
						kfcp_pkg::P_INIT : '0;
				end else begin
					v = rd;
				end
			end
		endcase
		return v;
	endfunction

	assign opa = opnd(ins.srca, rda_q);
	assign opb = opnd(ins.srcb, rdb_q);

	// scratch memory, registered reads
	always_ff @(posedge clk) begin
		if (st_q == ST_READ) begin
			rda_q <= mem[ins.srca[4:0]];
			rdb_q <= mem[ins.srcb[4:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// shared arithmetic units
	assign mul_go = (st_q == ST_EXEC) &&
		(ins.kind == kfcp_pkg::K_MUL || ins.kind == kfcp_pkg::K_RAW);
	assign div_go = (st_q == ST_EXEC) && (ins.kind == kfcp_pkg::K_DIV);

	kfcp_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_go),
		.a      (opa),
		.b      (opb),
		.done   (mul_done),
		.prod   (prod)
	);

	kfcp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go),
		.num    (opa),
		.neg    (ins.neg),
		.den    (det_q),
		.done   (div_done),
		.quo    (quo)
	);

	// accumulate the current term
	always_comb begin
		unique case (ins.kind)
			kfcp_pkg::K_ADD: term = kfcp_pkg::acc_t'(opa);
			kfcp_pkg::K_MUL: term = kfcp_pkg::acc_t'(kfcp_pkg::rnd_sat(prod));
			kfcp_pkg::K_RAW: term = kfcp_pkg::acc_t'(prod);
			kfcp_pkg::K_DIV: term = kfcp_pkg::acc_t'(quo);
		endcase
		acc_nx = (ins.neg && ins.kind != kfcp_pkg::K_DIV) ? acc_q - term : acc_q + term;
		det_wide = (acc_nx + kfcp_pkg::acc_t'(kfcp_pkg::HALF)) >>> kfcp_pkg::FRAC;
		det_nx = det_wide[47:0];
		wval = (ins.wmode == kfcp_pkg::W_CLAMP && acc_nx < 0) ? '0 : kfcp_pkg::sat(acc_nx);
	end

	assign step = ((st_q == ST_EXEC) && (ins.kind == kfcp_pkg::K_ADD)) ||
		((st_q == ST_WAIT) && (mul_done || div_done));

	assign wr.en = step && ins.last && (ins.wmode != kfcp_pkg::W_DET);
	assign wr.addr = ins.dest;
	assign wr.data = wval;
	assign done = step && (pc_q == kfcp_pkg::PC_LAST);
	assign busy = (st_q != ST_IDLE);

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			pc_q <= '0;
			acc_q <= '0;
			ok_q <= '0;
		end else begin
			if (wr.en && ins.dest < 5'(kfcp_pkg::N_STATE)) begin
				ok_q[ins.dest[2:0]] <= 1'b1;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (start) begin
						pc_q <= '0;
						acc_q <= '0;
						st_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (!(pc_q == kfcp_pkg::PC_COMMIT && hold)) begin
						st_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (ins.kind != kfcp_pkg::K_ADD) begin
						st_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
				end
			endcase
			if (step) begin
				acc_q <= ins.last ? '0 : acc_nx;
				st_q <= ST_READ;
				priority if (pc_q == kfcp_pkg::PC_DET && det_nx <= 0) begin
					pc_q <= kfcp_pkg::PC_COPY;
				end else if (pc_q == kfcp_pkg::PC_CEND) begin
					pc_q <= kfcp_pkg::PC_PRED;
				end else if (pc_q == kfcp_pkg::PC_LAST) begin
					pc_q <= '0;
					st_q <= ST_IDLE;
				end else begin
					pc_q <= pc_q + 7'd1;
				end
			end
		end
	end

	// determinant of the innovation covariance
	always_ff @(posedge clk) begin
		if (step && pc_q == kfcp_pkg::PC_DET) begin
			det_q <= det_nx;
		end
	end

endmodule

// File: src/kalman_filter_2state_correct_predict.sv
// Top level of the two-state Kalman filter: configuration registers, input
// latch, result register. Depends on kfcp_pkg and kfcp_seq.
`timescale 1ns / 1ps

// Usage
// - Input channel (in_valid/in_stall) carries meas_x/meas_y and drive_x/drive_y.
//   One item is taken at a time; in_stall stays high while an update runs.
// - Output channel (out_valid/out_stall) carries the predicted estimate and
//   covariance, one result per item, held in a result register.
// - Almost all of the time of an update is spent in the shared bit-serial
//   multiplier; when the correction runs, three passes of the bit-serial
//   divider add to it. The correction is skipped when the determinant is
//   non-positive. A new item is taken only once the previous update is done.
// - The next item is accepted while the previous result still waits; the
//   update runs up to the commit of the new state and then holds until the
//   result register is free.
// - Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once
//   and are meant for idle periods.
// - Reset loads the default registers (identity transition, zero process
//   noise, measurement noise 100.0) and the initial state (zero estimate,
//   variances 100.0) and empties the result register.
module kalman_filter_2state_correct_predict (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [31:0]  meas_x,
	input  logic signed [31:0]  meas_y,
	input  logic signed [31:0]  drive_x,
	input  logic signed [31:0]  drive_y,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  est_x,
	output logic signed [31:0]  est_y,
	output logic [30:0]         cov_xx,
	output logic signed [31:0]  cov_xy,
	output logic [30:0]         cov_yy
);

	kfcp_pkg::cfg_t  cfg_q;
	kfcp_pkg::val_t  y1_q;
	kfcp_pkg::val_t  y2_q;
	kfcp_pkg::val_t  u1_q;
	kfcp_pkg::val_t  u2_q;
	logic            out_valid_q;
	logic            busy;
	logic            done;
	logic            in_xfer;
	kfcp_pkg::wr_t   wr;

	assign in_stall = busy;
	assign in_xfer = in_valid && !busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.t11 <= 32'sd65536;
			cfg_q.t12 <= '0;
			cfg_q.t21 <= '0;
			cfg_q.t22 <= 32'sd65536;
			cfg_q.qx <= '0;
			cfg_q.qy <= '0;
			cfg_q.rx <= kfcp_pkg::P_INIT[30:0];
			cfg_q.ry <= kfcp_pkg::P_INIT[30:0];
		end else if (cfg_we) begin
			unique case (cfg_index)
				kfcp_pkg::R_T11: cfg_q.t11 <= cfg_data;
				kfcp_pkg::R_T12: cfg_q.t12 <= cfg_data;
				kfcp_pkg::R_T21: cfg_q.t21 <= cfg_data;
				kfcp_pkg::R_T22: cfg_q.t22 <= cfg_data;
				kfcp_pkg::R_QX:  cfg_q.qx <= cfg_data[30:0];
				kfcp_pkg::R_QY:  cfg_q.qy <= cfg_data[30:0];
				kfcp_pkg::R_RX:  cfg_q.rx <= cfg_data[30:0];
				kfcp_pkg::R_RY:  cfg_q.ry <= cfg_data[30:0];
			endcase
		end
	end

	// input latch
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			y1_q <= meas_x;
			y2_q <= meas_y;
			u1_q <= drive_x;
			u2_q <= drive_y;
		end
	end

	kfcp_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_xfer),
		.cfg    (cfg_q),
		.y1     (y1_q),
		.y2     (y2_q),
		.u1     (u1_q),
		.u2     (u2_q),
		.hold   (out_valid_q),
		.busy   (busy),
		.wr     (wr),
		.done   (done)
	);

	// result register, loaded as the new state is committed
	always_ff @(posedge clk) begin
		if (wr.en) begin
			unique case (6'(wr.addr))
				kfcp_pkg::A_X1:  est_x <= wr.data;
				kfcp_pkg::A_X2:  est_y <= wr.data;
				kfcp_pkg::A_P11: cov_xx <= wr.data[30:0];
				kfcp_pkg::A_P12: cov_xy <= wr.data;
				kfcp_pkg::A_P22: cov_yy <= wr.data[30:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: src/kfcp_chk.sv
// Port-level checker for the Kalman filter top level, attached by bind.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module kfcp_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               cfg_we,
	input logic [2:0]         cfg_index,
	input logic [31:0]        cfg_data,
	input logic               in_valid,
	input logic               in_stall,
	input logic signed [31:0] meas_x,
	input logic signed [31:0] meas_y,
	input logic signed [31:0] drive_x,
	input logic signed [31:0] drive_y,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] est_x,
	input logic signed [31:0] est_y,
	input logic [30:0]        cov_xx,
	input logic signed [31:0] cov_xy,
	input logic [30:0]        cov_yy
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps est_x, cov_xy and cov_xx
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(est_x) && $stable(cov_xy) && $stable(cov_xx))
		else $error("result payload changed while stalled");

	// an accepted item keeps the block busy in the next cycle
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("block free right after a transfer in");

	// a new result appears only as the block turns free
	a_result_frees: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("result raised while still busy");

endmodule

bind kalman_filter_2state_correct_predict kfcp_chk u_kfcp_chk (.*);

// File: tb/kfcp_checker.sv
// Checker for the two-state Kalman filter: watches the register port and both
// channels, keeps its own filter state and compares every result transfer.
// Depends on kfcp_pkg for the register indexes.
`timescale 1ns / 1ps

module kfcp_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [31:0] meas_x,
	input  logic signed [31:0] meas_y,
	input  logic signed [31:0] drive_x,
	input  logic signed [31:0] drive_y,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] est_x,
	input  logic signed [31:0] est_y,
	input  logic [30:0]        cov_xx,
	input  logic signed [31:0] cov_xy,
	input  logic [30:0]        cov_yy,
	output int                 errors,
	output int                 pending
);

	localparam longint VMAX = 64'sd2147483647;
	localparam longint VMIN = -64'sd2147483648;
	localparam longint UNIT = 64'sd65536;

	typedef struct {
		logic signed [31:0] ex;
		logic signed [31:0] ey;
		logic [30:0]        cxx;
		logic signed [31:0] cxy;
		logic [30:0]        cyy;
	} estimate_t;

	// filter copy: registers and state as wide integers
	longint a11, a12, a21, a22, qx, qy, rx, ry;
	longint xs1, xs2, pv11, pv12, pv22;
	estimate_t estimates[$];

	function automatic longint clip(input longint v);
		if (v > VMAX) return VMAX;
		if (v < VMIN) return VMIN;
		return v;
	endfunction

	// rounded Q16.16 product, saturated
	function automatic longint qmul(input longint a, input longint b);
		return clip((a * b + 64'sd32768) >>> 16);
	endfunction

	function automatic longint qdiv(input longint n, input longint d);
		return clip((n * UNIT) / d);
	endfunction

	// one correct-then-predict update; returns the new estimate
	function automatic estimate_t filter_update(input longint y1, input longint y2,
		input longint u1, input longint u2);
		longint xu1, xu2, g11, g12, g22, s11, s22, det;
		longint i11, i12, i22, k11, k12, k21, k22, e1, e2;
		longint m11, m12, m21, m22, n11, n12, n22;
		estimate_t r;
		xu1 = xs1; xu2 = xs2; g11 = pv11; g12 = pv12; g22 = pv22;
		s11 = clip(pv11 + rx);
		s22 = clip(pv22 + ry);
		det = (s11 * s22 - pv12 * pv12 + 64'sd32768) >>> 16;
		if (det > 0) begin
			i11 = qdiv(s22, det);
			i12 = qdiv(-pv12, det);
			i22 = qdiv(s11, det);
			k11 = clip(qmul(pv11, i11) + qmul(pv12, i12));
			k12 = clip(qmul(pv11, i12) + qmul(pv12, i22));
			k21 = clip(qmul(pv12, i11) + qmul(pv22, i12));
			k22 = clip(qmul(pv12, i12) + qmul(pv22, i22));
			e1 = clip(y1 - xs1);
			e2 = clip(y2 - xs2);
			xu1 = clip(xs1 + qmul(k11, e1) + qmul(k12, e2));
			xu2 = clip(xs2 + qmul(k21, e1) + qmul(k22, e2));
			g11 = clip(pv11 - qmul(k11, pv11) - qmul(k12, pv12));
			g12 = clip(pv12 - qmul(k11, pv12) - qmul(k12, pv22));
			g22 = clip(pv22 - qmul(k21, pv12) - qmul(k22, pv22));
		end
		m11 = clip(qmul(a11, g11) + qmul(a12, g12));
		m12 = clip(qmul(a11, g12) + qmul(a12, g22));
		m21 = clip(qmul(a21, g11) + qmul(a22, g12));
		m22 = clip(qmul(a21, g12) + qmul(a22, g22));
		n11 = qmul(m11, a11) + qmul(m12, a12) + qx;
		n12 = clip(qmul(m11, a21) + qmul(m12, a22));
		n22 = qmul(m21, a21) + qmul(m22, a22) + qy;
		xs1 = clip(qmul(a11, xu1) + qmul(a12, xu2) + u1);
		xs2 = clip(qmul(a21, xu1) + qmul(a22, xu2) + u2);
		pv11 = (n11 < 0) ? 0 : clip(n11);
		pv22 = (n22 < 0) ? 0 : clip(n22);
		pv12 = n12;
		r.ex = xs1[31:0];
		r.ey = xs2[31:0];
		r.cxx = pv11[30:0];
		r.cxy = n12[31:0];
		r.cyy = pv22[30:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		estimate_t want;
		longint u;
		if (!arst_n) begin
			a11 = UNIT; a12 = 0; a21 = 0; a22 = UNIT;
			qx = 0; qy = 0;
			rx = 100 * UNIT; ry = 100 * UNIT;
			xs1 = 0; xs2 = 0;
			pv11 = 100 * UNIT; pv22 = 100 * UNIT; pv12 = 0;
			estimates.delete();
			errors = 0;
			pending = 0;
		end else begin
			// register writes; unsigned registers drop the top bit
			if (cfg_we) begin
				u = longint'(cfg_data[30:0]);
				case (cfg_index)
					kfcp_pkg::R_T11: a11 = longint'($signed(cfg_data));
					kfcp_pkg::R_T12: a12 = longint'($signed(cfg_data));
					kfcp_pkg::R_T21: a21 = longint'($signed(cfg_data));
					kfcp_pkg::R_T22: a22 = longint'($signed(cfg_data));
					kfcp_pkg::R_QX: qx = u;
					kfcp_pkg::R_QY: qy = u;
					kfcp_pkg::R_RX: rx = u;
					kfcp_pkg::R_RY: ry = u;
					default: ;
				endcase
			end
			// result transfer against the oldest estimate
			if (out_valid && !out_stall) begin
				if (estimates.size() == 0) begin
					$error("result transfer with no estimate waiting");
					errors++;
				end else begin
					want = estimates.pop_front();
					if (est_x !== want.ex) begin
						$error("est_x: expected %0d, got %0d", want.ex, est_x);
						errors++;
					end
					if (est_y !== want.ey) begin
						$error("est_y: expected %0d, got %0d", want.ey, est_y);
						errors++;
					end
					if (cov_xx !== want.cxx) begin
						$error("cov_xx: expected %0d, got %0d", want.cxx, cov_xx);
						errors++;
					end
					if (cov_xy !== want.cxy) begin
						$error("cov_xy: expected %0d, got %0d", want.cxy, cov_xy);
						errors++;
					end
					if (cov_yy !== want.cyy) begin
						$error("cov_yy: expected %0d, got %0d", want.cyy, cov_yy);
						errors++;
					end
				end
			end
			// measurement transfer
			if (in_valid && !in_stall) begin
				estimates.push_back(filter_update(longint'(meas_x), longint'(meas_y),
					longint'(drive_x), longint'(drive_y)));
			end
			pending = estimates.size();
		end
	end

endmodule

// File: tb/kalman_filter_2state_correct_predict_test.sv
// Testbench top for the two-state Kalman filter: clock, reset, register
// phases, measurement stimulus and result-side stalls. Depends on kfcp_pkg,
// kfcp_checker and the block itself.
`timescale 1ns / 1ps

module kalman_filter_2state_correct_predict_test;

	localparam longint CYCLE_LIMIT = 64'd12000000;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic signed [31:0] meas_x, meas_y, drive_x, drive_y;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] est_x, est_y, cov_xy;
	logic [30:0]        cov_xx, cov_yy;
	int                 errors;
	int                 pending;
	longint             cycles;
	logic               first_item;

	kalman_filter_2state_correct_predict DUT (.*);

	kfcp_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run guard
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// result side: bursts of stall, mostly short, sometimes long
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			repeat ($urandom_range(0, 9) < 7 ? $urandom_range(1, 6) : $urandom_range(50, 400))
				@(posedge clk);
			out_stall <= ($urandom_range(0, 2) == 0);
		end
	end

	function automatic logic [31:0] rand_value();
		if ($urandom_range(0, 4) == 0) return $urandom;
		return $urandom_range(0, 1) ? $urandom_range(0, 32'h003fffff)
			: -$urandom_range(0, 32'h003fffff);
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// only once every estimate has come back
	task automatic wait_idle();
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_all(input logic [31:0] t11, t12, t21, t22, nqx, nqy, nrx, nry);
		wait_idle();
		write_reg(kfcp_pkg::R_T11, t11);
		write_reg(kfcp_pkg::R_T12, t12);
		write_reg(kfcp_pkg::R_T21, t21);
		write_reg(kfcp_pkg::R_T22, t22);
		write_reg(kfcp_pkg::R_QX, nqx);
		write_reg(kfcp_pkg::R_QY, nqy);
		write_reg(kfcp_pkg::R_RX, nrx);
		write_reg(kfcp_pkg::R_RY, nry);
	endtask

	// one measurement transfer, with a random gap before it
	task automatic send(input logic [31:0] mx, my, dx, dy);
		int gap;
		gap = first_item ? 0 : ($urandom_range(0, 9) < 8 ? $urandom_range(0, 3)
			: $urandom_range(20, 300));
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		first_item = 1'b0;
		in_valid <= 1'b1;
		meas_x <= mx;
		meas_y <= my;
		drive_x <= dx;
		drive_y <= dy;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic stop_sending();
		in_valid <= 1'b0;
		@(posedge clk);
		first_item = 1'b1;
	endtask

	function automatic logic [31:0] near_one();
		logic [31:0] v;
		v = $urandom_range(32768, 98304);
		return $urandom_range(0, 5) == 0 ? -v : v;
	endfunction

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		meas_x = '0; meas_y = '0; drive_x = '0; drive_y = '0;
		first_item = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default registers: zero, extreme and small measurements
		send(32'h0, 32'h0, 32'h0, 32'h0);
		send(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
		send(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
		send(32'hffffffff, 32'h00000001, 32'h00010000, 32'hffff0000);
		send(32'h00050000, 32'hfffb0000, 32'h0, 32'h0);
		stop_sending();

		// zero transition and noise: covariance collapses, S turns singular
		write_all(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
		send(32'h00030000, 32'h00040000, 32'h00010000, 32'h00020000);
		send(32'h00030000, 32'h00040000, 32'h00010000, 32'h00020000);
		send(32'hfff00000, 32'h00100000, 32'h0, 32'h0);
		stop_sending();

		// extreme registers, top bit of unsigned writes ignored, S saturates
		write_all(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
			32'hffffffff, 32'h0, 32'h7fffffff, 32'h80000000);
		send(32'h7fffffff, 32'h80000000, 32'h0, 32'h0);
		send(32'h12345678, 32'h87654321, 32'h7fffffff, 32'h80000000);
		send(32'h80000000, 32'h7fffffff, 32'hffffffff, 32'h1);
		stop_sending();

		// negative transition entries, large noise: clamped variances
		write_all(32'hffff0000, 32'h00020000, 32'h80000000, 32'h00008000,
			32'h0, 32'h7fffffff, 32'h0, 32'h00000001);
		send(32'h00010000, 32'hffff0000, 32'h0, 32'h0);
		send(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000);
		send(32'h0, 32'h0, 32'h0, 32'h0);
		stop_sending();

		// random phases with register settings between them
		for (int ph = 0; ph < 7; ph++) begin
			if (ph == 6) begin
				write_all($urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom);
			end else begin
				write_all(near_one(), $urandom_range(0, 16384), $urandom_range(0, 16384),
					near_one(), $urandom_range(0, 32'h00100000),
					$urandom_range(0, 32'h00100000), $urandom_range(0, 32'h01400000),
					$urandom_range(0, 32'h01400000));
			end
			for (int n = 0; n < 148; n++) begin
				send(rand_value(), rand_value(), rand_value(), rand_value());
			end
			stop_sending();
		end

		wait_idle();
		repeat (2000) @(posedge clk);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// File: sim.f
src/kfcp_pkg.sv
src/kfcp_mul.sv
src/kfcp_div.sv
src/kfcp_seq.sv
src/kalman_filter_2state_correct_predict.sv
src/kfcp_chk.sv
tb/kfcp_checker.sv
tb/kalman_filter_2state_correct_predict_test.sv
